// ----- rtl/tsgd_pkg.sv -----
// Shared types and constants for the touch swipe gesture detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tsgd_pkg;

    // Input event kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_KEY   = 3'd1;
    localparam logic [2:0] KIND_X     = 3'd2;
    localparam logic [2:0] KIND_Y     = 3'd3;
    localparam logic [2:0] KIND_TOUCH = 3'd4;

    // Gesture codes
    localparam logic [2:0] GEST_UP    = 3'd0;
    localparam logic [2:0] GEST_DOWN  = 3'd1;
    localparam logic [2:0] GEST_LEFT  = 3'd2;
    localparam logic [2:0] GEST_RIGHT = 3'd3;
    localparam logic [2:0] GEST_DTAP  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SWIPE_THR = 2'd0;
    localparam logic [1:0] CFG_COOLDOWN  = 2'd1;
    localparam logic [1:0] CFG_TAP_THR   = 2'd2;
    localparam logic [1:0] CFG_DTAP_MS   = 2'd3;

    // Configuration reset values
    localparam logic [14:0] RST_SWIPE_THR = 15'd30;
    localparam logic [15:0] RST_COOLDOWN  = 16'd400;
    localparam logic [14:0] RST_TAP_THR   = 15'd10;
    localparam logic [15:0] RST_DTAP_MS   = 16'd350;

    localparam logic [15:0] MS_SATURATED = 16'hFFFF;
    localparam logic [15:0] KEY_PRESS    = 16'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [1:0]  key_dir;
        logic        ui_busy;
        logic        settings_busy;
    } t_in_item;

    typedef struct packed {
        logic        gesture_valid;
        logic [2:0]  gesture;
        logic        report_valid;
        logic [15:0] report_x;
        logic [15:0] report_y;
        logic        touched;
        logic        swiping;
    } t_out_item;

    typedef struct packed {
        logic [14:0] swipe_min;
        logic [15:0] cooldown_ms;
        logic [14:0] tap_threshold;
        logic [15:0] double_tap_ms;
    } t_cfg;

    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step_res;

endpackage

`default_nettype wire

// ----- rtl/tsgd_cfg.sv -----
// APB configuration registers of the gesture detector.
// Depends on tsgd_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module tsgd_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tsgd_pkg::t_cfg     o_cfg
);

    logic [14:0] r_swipe_thr;
    logic [15:0] r_cooldown;
    logic [14:0] r_tap_thr;
    logic [15:0] r_dtap_ms;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_thr <= tsgd_pkg::RST_SWIPE_THR;
            r_cooldown  <= tsgd_pkg::RST_COOLDOWN;
            r_tap_thr   <= tsgd_pkg::RST_TAP_THR;
            r_dtap_ms   <= tsgd_pkg::RST_DTAP_MS;
        end else if (wr_en) begin
            case (idx)
                tsgd_pkg::CFG_SWIPE_THR: r_swipe_thr <= pwdata[14:0];
                tsgd_pkg::CFG_COOLDOWN:  r_cooldown  <= pwdata[15:0];
                tsgd_pkg::CFG_TAP_THR:   r_tap_thr   <= pwdata[14:0];
                tsgd_pkg::CFG_DTAP_MS:   r_dtap_ms   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            tsgd_pkg::CFG_SWIPE_THR: prdata = {17'd0, r_swipe_thr};
            tsgd_pkg::CFG_COOLDOWN:  prdata = {16'd0, r_cooldown};
            tsgd_pkg::CFG_TAP_THR:   prdata = {17'd0, r_tap_thr};
            tsgd_pkg::CFG_DTAP_MS:   prdata = {16'd0, r_dtap_ms};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{swipe_min: r_swipe_thr, cooldown_ms: r_cooldown,
                     tap_threshold: r_tap_thr, double_tap_ms: r_dtap_ms};

endmodule

`default_nettype wire

// ----- rtl/tsgd_state.sv -----
// Gesture state registers and the single-pass classification of one event.
// Depends on tsgd_pkg for item types, codes and the configuration struct.
`default_nettype none

module tsgd_state (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsgd_pkg::t_cfg     i_cfg,
    input  wire tsgd_pkg::t_in_item i_item,
    input  wire logic               i_commit,
    output tsgd_pkg::t_step_res     o_res
);

    logic [15:0] r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic        r_in_progress, r_already_raised, r_touch_now, r_touch_before, r_tap_armed;
    logic [15:0] r_since_gest, r_since_tap;

    logic [15:0] n_cur_x, n_cur_y, n_start_x, n_start_y;
    logic        n_in_progress, n_already_raised, n_touch_now, n_touch_before, n_tap_armed;
    logic [15:0] n_since_gest, n_since_tap;

    logic [15:0] raw_dx, raw_dy, dx, dy, ax, ay;
    logic        dx_pos, dy_pos, busy, raise_ok, pressed;
    logic        swipe_v, swipe_h, is_tap, dtap_hit;
    logic        gvalid, report, has_result;
    logic [2:0]  gcode;

    // Rotated displacement and magnitudes
    assign raw_dx   = r_cur_x - r_start_x;
    assign raw_dy   = r_cur_y - r_start_y;
    assign dx       = raw_dy;
    assign dy       = 16'd0 - raw_dx;
    assign ax       = dx[15] ? (16'd0 - dx) : dx;
    assign ay       = dy[15] ? (16'd0 - dy) : dy;
    assign dx_pos   = (dx != 16'd0) && !dx[15];
    assign dy_pos   = (dy != 16'd0) && !dy[15];

    assign busy     = i_item.ui_busy || i_item.settings_busy;
    assign raise_ok = (r_since_gest >= i_cfg.cooldown_ms) && !busy;
    assign pressed  = i_item.value != 16'd0;

    assign swipe_v  = (ay > ax) && (ay > {1'b0, i_cfg.swipe_min});
    assign swipe_h  = !swipe_v && (ax > ay) && (ax > {1'b0, i_cfg.swipe_min});
    assign is_tap   = (ax <= {1'b0, i_cfg.tap_threshold}) && (ay <= {1'b0, i_cfg.tap_threshold});
    assign dtap_hit = r_tap_armed && (r_since_tap < i_cfg.double_tap_ms);

    // Next state and result for the event
    always_comb begin
        n_cur_x          = r_cur_x;
        n_cur_y          = r_cur_y;
        n_start_x        = r_start_x;
        n_start_y        = r_start_y;
        n_in_progress    = r_in_progress;
        n_already_raised = r_already_raised;
        n_touch_now      = r_touch_now;
        n_touch_before   = r_touch_before;
        n_tap_armed      = r_tap_armed;
        n_since_gest     = r_since_gest;
        n_since_tap      = r_since_tap;
        gvalid           = 1'b0;
        gcode            = tsgd_pkg::GEST_UP;
        report           = 1'b0;
        has_result       = 1'b0;

        case (i_item.kind)
            tsgd_pkg::KIND_TICK: begin
                if (r_since_gest != tsgd_pkg::MS_SATURATED) n_since_gest = r_since_gest + 16'd1;
                if (r_since_tap != tsgd_pkg::MS_SATURATED)  n_since_tap  = r_since_tap + 16'd1;
            end
            tsgd_pkg::KIND_KEY: begin
                if (i_item.value == tsgd_pkg::KEY_PRESS && !i_item.ui_busy) begin
                    n_already_raised = 1'b1;
                    if (raise_ok) begin
                        gvalid       = 1'b1;
                        gcode        = {1'b0, i_item.key_dir};
                        n_since_gest = 16'd0;
                    end
                end
                has_result = gvalid;
            end
            tsgd_pkg::KIND_X: n_cur_x = i_item.value;
            tsgd_pkg::KIND_Y: n_cur_y = i_item.value;
            tsgd_pkg::KIND_TOUCH: begin
                report      = 1'b1;
                has_result  = 1'b1;
                n_touch_now = pressed;
                if (pressed && !r_touch_before) begin
                    // Touch start: latch the start point
                    n_start_x        = r_cur_x;
                    n_start_y        = r_cur_y;
                    n_in_progress    = 1'b1;
                    n_already_raised = busy;
                end else if (!pressed) begin
                    // Release: classify the displacement
                    if (!r_already_raised && r_in_progress && !i_item.ui_busy) begin
                        if (swipe_v) begin
                            if (raise_ok) begin
                                gvalid       = 1'b1;
                                gcode        = dy_pos ? tsgd_pkg::GEST_DOWN : tsgd_pkg::GEST_UP;
                                n_since_gest = 16'd0;
                            end
                        end else if (swipe_h) begin
                            if (raise_ok) begin
                                gvalid       = 1'b1;
                                gcode        = dx_pos ? tsgd_pkg::GEST_RIGHT
                                                      : tsgd_pkg::GEST_LEFT;
                                n_since_gest = 16'd0;
                            end
                        end else if (is_tap) begin
                            if (dtap_hit) begin
                                n_tap_armed = 1'b0;
                                if (raise_ok) begin
                                    gvalid       = 1'b1;
                                    gcode        = tsgd_pkg::GEST_DTAP;
                                    n_since_gest = 16'd0;
                                end
                            end else begin
                                n_tap_armed = 1'b1;
                                n_since_tap = 16'd0;
                            end
                        end
                    end
                    n_in_progress    = 1'b0;
                    n_already_raised = 1'b0;
                end
                n_touch_before = pressed;
            end
            default: ;
        endcase
    end

    // Advance the state when the event is committed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x          <= 16'd0;
            r_cur_y          <= 16'd0;
            r_start_x        <= 16'd0;
            r_start_y        <= 16'd0;
            r_in_progress    <= 1'b0;
            r_already_raised <= 1'b0;
            r_touch_now      <= 1'b0;
            r_touch_before   <= 1'b0;
            r_tap_armed      <= 1'b0;
            r_since_gest     <= tsgd_pkg::MS_SATURATED;
            r_since_tap      <= tsgd_pkg::MS_SATURATED;
        end else if (i_commit) begin
            r_cur_x          <= n_cur_x;
            r_cur_y          <= n_cur_y;
            r_start_x        <= n_start_x;
            r_start_y        <= n_start_y;
            r_in_progress    <= n_in_progress;
            r_already_raised <= n_already_raised;
            r_touch_now      <= n_touch_now;
            r_touch_before   <= n_touch_before;
            r_tap_armed      <= n_tap_armed;
            r_since_gest     <= n_since_gest;
            r_since_tap      <= n_since_tap;
        end
    end

    assign o_res.has_result         = has_result;
    assign o_res.item.gesture_valid = gvalid;
    assign o_res.item.gesture       = gvalid ? gcode : 3'd0;
    assign o_res.item.report_valid  = report;
    assign o_res.item.report_x      = report ? n_cur_x : 16'd0;
    assign o_res.item.report_y      = report ? n_cur_y : 16'd0;
    assign o_res.item.touched       = n_touch_now;
    assign o_res.item.swiping       = n_in_progress;

endmodule

`default_nettype wire

// ----- rtl/touch_swipe_gesture_detector_core.sv -----
// An accepted event is held in the input register and classified in a single pass; its
// result is then loaded into the result register and offered from there.
// Throughput: one event per cycle; an event with a result waits in the input register
// only while a stalled beat holds the result register, and that stalls the input.
// Reset clears the handshake, the touch state and the tap flag, saturates both
// millisecond counters and loads the default thresholds and intervals.
`default_nettype none

module touch_swipe_gesture_detector_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tsgd_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tsgd_pkg::t_out_item      o_out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    tsgd_pkg::t_cfg      cfg;
    tsgd_pkg::t_step_res res;
    tsgd_pkg::t_in_item  r_s1_item;
    tsgd_pkg::t_out_item r_out_item;
    logic                r_s1_valid, r_out_valid;
    logic                out_free, s1_go;

    tsgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tsgd_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .i_commit (s1_go),
        .o_res    (res)
    );

    // Stage one advances when its result, if any, has room
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!res.has_result || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;

    // Input register: take a beat whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    // Result register: load a new result, drop a delivered one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res.has_result) begin
            r_out_item <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/tsgd_checker.sv -----
// Port-level checks for the gesture detector, attached to the top level by bind.
// Depends on tsgd_pkg for the item types and gesture codes.
`default_nettype none

module tsgd_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire tsgd_pkg::t_out_item o_out_item
);

    // Every result carries a report or a gesture
    a_result_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.report_valid || o_out_item.gesture_valid))
        else $error("result beat with neither report nor gesture");

    // Gesture code is cleared without a gesture and legal with one
    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.gesture_valid ? (o_out_item.gesture <= tsgd_pkg::GEST_DTAP)
                                                  : (o_out_item.gesture == 3'd0)))
        else $error("bad gesture code");

    // Point is cleared without a report
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.report_valid) |->
            (o_out_item.report_x == 16'd0 && o_out_item.report_y == 16'd0))
        else $error("point present without report");

    // A gesture in progress implies the touch is held
    a_swipe_needs_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.swiping) |-> o_out_item.touched)
        else $error("swiping without touch");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind touch_swipe_gesture_detector_core tsgd_checker u_tsgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
